// ----- hw/rtl/adwc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adwc_pkg
// shared types, widths and datapath commands for the audio dma window cache
// ----------------------------------------------------------------------------
package adwc_pkg;

    localparam int LINK_W          = 8;
    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 16;
    localparam int FRAME_W         = 32;
    localparam int IDX_OUT_W       = 7;
    localparam int OFF_W           = 10;
    localparam int TAG_W           = 8;
    localparam int NUM_BUFFERS_DEF = 128;
    localparam int BUFFER_BYTES_DEF = 512;

    localparam logic [LINK_W-1:0] NIL     = 8'hFF;
    localparam logic [TAG_W-1:0]  TAG_MAX = 8'hFF;

    typedef logic [LINK_W-1:0] link_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRD,
        OP_WSTEP,
        OP_HIT,
        OP_EXH,
        OP_MRD,
        OP_MUNL,
        OP_MLRD,
        OP_MLA,
        OP_MLB,
        OP_MHA,
        OP_MHB,
        OP_MEMP,
        OP_MOUT,
        OP_SRD,
        OP_SUNL,
        OP_SSKIP,
        OP_SFRD,
        OP_SFA,
        OP_SFB,
        OP_SFE,
        OP_SDONE
    } dp_op_t;

    typedef struct packed {
        logic cur_ok;
        logic above;
        logic covers;
        logic stale;
        logic free_ok;
        logic last_ok;
        logic used_ok;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/adwc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adwc_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module adwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                  wdata,
    input  wire logic                              re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/adwc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adwc_ctrl
// sequencer for list walks, buffer allocation and the frame-end sweep
// ----------------------------------------------------------------------------
module adwc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  req_type,
    output logic                       in_stall,
    input  wire adwc_pkg::dp_status_t  st,
    output adwc_pkg::dp_op_t           op
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_W_RD,
        ST_W_CHK,
        ST_HIT,
        ST_M_DEC,
        ST_EXH,
        ST_M_UNL,
        ST_M_LRD,
        ST_M_LA,
        ST_M_LB,
        ST_M_HA,
        ST_M_HB,
        ST_M_EMP,
        ST_M_OUT,
        ST_S_RD,
        ST_S_CHK,
        ST_S_FRD,
        ST_S_FA,
        ST_S_FB,
        ST_S_FE,
        ST_S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = adwc_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = adwc_pkg::OP_LOAD;
                    state_next = req_type ? ST_S_RD : ST_W_RD;
                end
            end
            ST_W_RD:
            begin
                if (!st.cur_ok)
                begin
                    state_next = ST_M_DEC;
                end
                else
                begin
                    op         = adwc_pkg::OP_WRD;
                    state_next = ST_W_CHK;
                end
            end
            ST_W_CHK:
            begin
                if (st.above)
                begin
                    state_next = ST_M_DEC;
                end
                else if (st.covers)
                begin
                    state_next = ST_HIT;
                end
                else
                begin
                    op         = adwc_pkg::OP_WSTEP;
                    state_next = ST_W_RD;
                end
            end
            ST_HIT:
            begin
                if (st.out_free)
                begin
                    op         = adwc_pkg::OP_HIT;
                    state_next = ST_IDLE;
                end
            end
            ST_M_DEC:
            begin
                if (!st.free_ok)
                begin
                    state_next = ST_EXH;
                end
                else
                begin
                    op         = adwc_pkg::OP_MRD;
                    state_next = ST_M_UNL;
                end
            end
            ST_EXH:
            begin
                if (st.out_free)
                begin
                    op         = adwc_pkg::OP_EXH;
                    state_next = ST_IDLE;
                end
            end
            ST_M_UNL:
            begin
                op = adwc_pkg::OP_MUNL;
                if (st.last_ok)
                begin
                    state_next = ST_M_LRD;
                end
                else if (st.used_ok)
                begin
                    state_next = ST_M_HA;
                end
                else
                begin
                    state_next = ST_M_EMP;
                end
            end
            ST_M_LRD:
            begin
                op         = adwc_pkg::OP_MLRD;
                state_next = ST_M_LA;
            end
            ST_M_LA:
            begin
                op         = adwc_pkg::OP_MLA;
                state_next = ST_M_LB;
            end
            ST_M_LB:
            begin
                op         = adwc_pkg::OP_MLB;
                state_next = ST_M_OUT;
            end
            ST_M_HA:
            begin
                op         = adwc_pkg::OP_MHA;
                state_next = ST_M_HB;
            end
            ST_M_HB:
            begin
                op         = adwc_pkg::OP_MHB;
                state_next = ST_M_OUT;
            end
            ST_M_EMP:
            begin
                op         = adwc_pkg::OP_MEMP;
                state_next = ST_M_OUT;
            end
            ST_M_OUT:
            begin
                if (st.out_free)
                begin
                    op         = adwc_pkg::OP_MOUT;
                    state_next = ST_IDLE;
                end
            end
            ST_S_RD:
            begin
                if (!st.cur_ok)
                begin
                    state_next = ST_S_DONE;
                end
                else
                begin
                    op         = adwc_pkg::OP_SRD;
                    state_next = ST_S_CHK;
                end
            end
            ST_S_CHK:
            begin
                if (st.stale)
                begin
                    op         = adwc_pkg::OP_SUNL;
                    state_next = st.free_ok ? ST_S_FRD : ST_S_FE;
                end
                else
                begin
                    op         = adwc_pkg::OP_SSKIP;
                    state_next = ST_S_RD;
                end
            end
            ST_S_FRD:
            begin
                op         = adwc_pkg::OP_SFRD;
                state_next = ST_S_FA;
            end
            ST_S_FA:
            begin
                op         = adwc_pkg::OP_SFA;
                state_next = ST_S_FB;
            end
            ST_S_FB:
            begin
                op         = adwc_pkg::OP_SFB;
                state_next = ST_S_RD;
            end
            ST_S_FE:
            begin
                op         = adwc_pkg::OP_SFE;
                state_next = ST_S_RD;
            end
            ST_S_DONE:
            begin
                if (st.out_free)
                begin
                    op         = adwc_pkg::OP_SDONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/adwc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adwc_dp
// buffer tables, list pointers, compare logic and result register
// ----------------------------------------------------------------------------
module adwc_dp #(
    parameter int NUM_BUFFERS  = adwc_pkg::NUM_BUFFERS_DEF,
    parameter int BUFFER_BYTES = adwc_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire adwc_pkg::dp_op_t                  op,
    output adwc_pkg::dp_status_t                   st,
    input  wire logic [adwc_pkg::ADDR_W-1:0]       rom_addr,
    input  wire logic [adwc_pkg::LEN_W-1:0]        length,
    input  wire logic [adwc_pkg::FRAME_W-1:0]      frame,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic [adwc_pkg::IDX_OUT_W-1:0]         buffer_index,
    output logic [adwc_pkg::OFF_W-1:0]             byte_offset,
    output logic                                   fetch_start,
    output logic [adwc_pkg::ADDR_W-1:0]            fetch_addr,
    output logic [adwc_pkg::TAG_W-1:0]             fetch_tag,
    output logic                                   pool_exhausted
);

    localparam int AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam adwc_pkg::link_t NB = adwc_pkg::LINK_W'(NUM_BUFFERS);

    function automatic logic is_idx(input adwc_pkg::link_t x);
        return x < NB;
    endfunction

    // request fields held while the item is worked on
    logic [adwc_pkg::ADDR_W-1:0]   addr_reg;
    logic [adwc_pkg::LEN_W-1:0]    len_reg;
    logic [adwc_pkg::FRAME_W-1:0]  frame_reg;

    adwc_pkg::link_t cur_reg, last_reg, d_reg, tmp_reg, nx_reg;
    adwc_pkg::link_t guard_reg;
    adwc_pkg::link_t used_head_reg, free_head_reg;
    logic [adwc_pkg::TAG_W-1:0] fetch_count_reg;
    logic [NUM_BUFFERS-1:0]     nvld_reg, pvld_reg;

    adwc_pkg::link_t rd_addr_reg;
    logic            nvld_q_reg, pvld_q_reg;

    logic                            out_valid_reg;
    logic                            hit_reg;
    logic [adwc_pkg::IDX_OUT_W-1:0]  idx_reg;
    logic [adwc_pkg::OFF_W-1:0]      off_reg;
    logic                            fst_reg;
    logic [adwc_pkg::ADDR_W-1:0]     fad_reg;
    logic [adwc_pkg::TAG_W-1:0]      tag_reg;
    logic                            exh_reg;

    // ram ports
    logic                         re;
    adwc_pkg::link_t              raddr;
    logic                         s_we, f_we, n_we, p_we;
    adwc_pkg::link_t              s_wa, f_wa, n_wa, p_wa;
    logic [adwc_pkg::ADDR_W-1:0]  s_wd;
    logic [adwc_pkg::FRAME_W-1:0] f_wd;
    adwc_pkg::link_t              n_wd, p_wd;
    logic [adwc_pkg::ADDR_W-1:0]  s_rd;
    logic [adwc_pkg::FRAME_W-1:0] f_rd;
    adwc_pkg::link_t              n_ram_rd, p_ram_rd;
    adwc_pkg::link_t              next_rd, prev_rd;
    adwc_pkg::link_t              rst_next, rst_prev;
    logic [adwc_pkg::FRAME_W-1:0] f_inc;
    logic [adwc_pkg::ADDR_W:0]    want_end, buf_end;
    logic [adwc_pkg::ADDR_W-1:0]  hit_off;
    logic                         beat_set;

    adwc_ram #(.WIDTH(adwc_pkg::ADDR_W), .DEPTH(NUM_BUFFERS)) u_start (
        .clk(clk), .we(s_we), .waddr(s_wa[AW-1:0]), .wdata(s_wd),
        .re(re), .raddr(raddr[AW-1:0]), .rdata(s_rd)
    );

    adwc_ram #(.WIDTH(adwc_pkg::FRAME_W), .DEPTH(NUM_BUFFERS)) u_frame (
        .clk(clk), .we(f_we), .waddr(f_wa[AW-1:0]), .wdata(f_wd),
        .re(re), .raddr(raddr[AW-1:0]), .rdata(f_rd)
    );

    adwc_ram #(.WIDTH(adwc_pkg::LINK_W), .DEPTH(NUM_BUFFERS)) u_next (
        .clk(clk), .we(n_we), .waddr(n_wa[AW-1:0]), .wdata(n_wd),
        .re(re), .raddr(raddr[AW-1:0]), .rdata(n_ram_rd)
    );

    adwc_ram #(.WIDTH(adwc_pkg::LINK_W), .DEPTH(NUM_BUFFERS)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_wa[AW-1:0]), .wdata(p_wd),
        .re(re), .raddr(raddr[AW-1:0]), .rdata(p_ram_rd)
    );

    // links never written since reset read as the initial chain
    always_comb
    begin
        rst_next = (rd_addr_reg + 8'd1 < NB) ? rd_addr_reg + 8'd1 : adwc_pkg::NIL;
        rst_prev = (rd_addr_reg == 8'd0) ? adwc_pkg::NIL : rd_addr_reg - 8'd1;
        next_rd  = nvld_q_reg ? n_ram_rd : rst_next;
        prev_rd  = pvld_q_reg ? p_ram_rd : rst_prev;
        f_inc    = f_rd + 32'd1;
        want_end = {1'b0, addr_reg} + 33'(len_reg);
        buf_end  = {1'b0, s_rd} + 33'(BUFFER_BYTES);
        hit_off  = addr_reg - s_rd;
    end

    always_comb
    begin
        st.cur_ok   = is_idx(cur_reg) && (guard_reg < NB);
        st.above    = s_rd > addr_reg;
        st.covers   = want_end <= buf_end;
        st.stale    = f_inc < frame_reg;
        st.free_ok  = is_idx(free_head_reg);
        st.last_ok  = is_idx(last_reg);
        st.used_ok  = is_idx(used_head_reg);
        st.out_free = !out_valid_reg || !out_stall;
    end

    assign beat_set = (op == adwc_pkg::OP_HIT) || (op == adwc_pkg::OP_EXH)
                   || (op == adwc_pkg::OP_SDONE) || (op == adwc_pkg::OP_MOUT);

    // read address and table writes per command
    always_comb
    begin
        re    = 1'b0;
        raddr = cur_reg;
        s_we  = 1'b0;
        s_wa  = d_reg;
        s_wd  = {addr_reg[adwc_pkg::ADDR_W-1:1], 1'b0};
        f_we  = 1'b0;
        f_wa  = d_reg;
        f_wd  = frame_reg;
        n_we  = 1'b0;
        n_wa  = d_reg;
        n_wd  = adwc_pkg::NIL;
        p_we  = 1'b0;
        p_wa  = d_reg;
        p_wd  = adwc_pkg::NIL;
        case (op)
            adwc_pkg::OP_WRD,
            adwc_pkg::OP_SRD:
            begin
                re    = 1'b1;
                raddr = cur_reg;
            end
            adwc_pkg::OP_MRD,
            adwc_pkg::OP_SFRD:
            begin
                re    = 1'b1;
                raddr = free_head_reg;
            end
            adwc_pkg::OP_MLRD:
            begin
                re    = 1'b1;
                raddr = last_reg;
            end
            adwc_pkg::OP_HIT:
            begin
                f_we = 1'b1;
                f_wa = cur_reg;
            end
            adwc_pkg::OP_MUNL,
            adwc_pkg::OP_SUNL:
            begin
                s_we = (op == adwc_pkg::OP_MUNL);
                f_we = (op == adwc_pkg::OP_MUNL);
                n_we = is_idx(prev_rd);
                n_wa = prev_rd;
                n_wd = next_rd;
                p_we = is_idx(next_rd);
                p_wa = next_rd;
                p_wd = prev_rd;
            end
            adwc_pkg::OP_MLA:
            begin
                n_we = 1'b1;
                n_wd = next_rd;
                p_we = 1'b1;
                p_wd = last_reg;
            end
            adwc_pkg::OP_MLB:
            begin
                n_we = 1'b1;
                n_wa = last_reg;
                n_wd = d_reg;
                p_we = is_idx(tmp_reg);
                p_wa = tmp_reg;
                p_wd = d_reg;
            end
            adwc_pkg::OP_MHA:
            begin
                n_we = 1'b1;
                n_wd = used_head_reg;
                p_we = 1'b1;
            end
            adwc_pkg::OP_MHB:
            begin
                p_we = 1'b1;
                p_wa = used_head_reg;
                p_wd = d_reg;
            end
            adwc_pkg::OP_MEMP:
            begin
                n_we = 1'b1;
                p_we = 1'b1;
            end
            adwc_pkg::OP_SFA:
            begin
                n_we = 1'b1;
                n_wa = cur_reg;
                n_wd = next_rd;
                p_we = 1'b1;
                p_wa = cur_reg;
                p_wd = free_head_reg;
            end
            adwc_pkg::OP_SFB:
            begin
                n_we = 1'b1;
                n_wa = free_head_reg;
                n_wd = cur_reg;
                p_we = is_idx(tmp_reg);
                p_wa = tmp_reg;
                p_wd = cur_reg;
            end
            adwc_pkg::OP_SFE:
            begin
                n_we = 1'b1;
                n_wa = cur_reg;
                p_we = 1'b1;
                p_wa = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_head_reg   <= adwc_pkg::NIL;
            free_head_reg   <= 8'd0;
            fetch_count_reg <= '0;
            nvld_reg        <= '0;
            pvld_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (n_we)
            begin
                nvld_reg[n_wa[AW-1:0]] <= 1'b1;
            end
            if (p_we)
            begin
                pvld_reg[p_wa[AW-1:0]] <= 1'b1;
            end
            if (beat_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                adwc_pkg::OP_SDONE:
                begin
                    fetch_count_reg <= '0;
                end
                adwc_pkg::OP_MOUT:
                begin
                    if (fetch_count_reg != adwc_pkg::TAG_MAX)
                    begin
                        fetch_count_reg <= fetch_count_reg + 8'd1;
                    end
                end
                adwc_pkg::OP_MUNL:
                begin
                    free_head_reg <= is_idx(next_rd) ? next_rd : adwc_pkg::NIL;
                end
                adwc_pkg::OP_MHB,
                adwc_pkg::OP_MEMP:
                begin
                    used_head_reg <= d_reg;
                end
                adwc_pkg::OP_SUNL:
                begin
                    if (used_head_reg == cur_reg)
                    begin
                        used_head_reg <= next_rd;
                    end
                end
                adwc_pkg::OP_SFE:
                begin
                    free_head_reg <= cur_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_addr_reg <= raddr;
            nvld_q_reg  <= nvld_reg[raddr[AW-1:0]];
            pvld_q_reg  <= pvld_reg[raddr[AW-1:0]];
        end
        case (op)
            adwc_pkg::OP_LOAD:
            begin
                addr_reg  <= rom_addr;
                len_reg   <= length;
                frame_reg <= frame;
                cur_reg   <= used_head_reg;
                last_reg  <= adwc_pkg::NIL;
                guard_reg <= '0;
            end
            adwc_pkg::OP_WSTEP:
            begin
                guard_reg <= guard_reg + 8'd1;
                last_reg  <= cur_reg;
                cur_reg   <= next_rd;
            end
            adwc_pkg::OP_MRD:
            begin
                d_reg <= free_head_reg;
            end
            adwc_pkg::OP_MLA,
            adwc_pkg::OP_SFA:
            begin
                tmp_reg <= next_rd;
            end
            adwc_pkg::OP_SUNL:
            begin
                guard_reg <= guard_reg + 8'd1;
                nx_reg    <= next_rd;
            end
            adwc_pkg::OP_SSKIP:
            begin
                guard_reg <= guard_reg + 8'd1;
                cur_reg   <= next_rd;
            end
            adwc_pkg::OP_SFB,
            adwc_pkg::OP_SFE:
            begin
                cur_reg <= nx_reg;
            end
            adwc_pkg::OP_HIT:
            begin
                hit_reg <= 1'b1;
                idx_reg <= cur_reg[adwc_pkg::IDX_OUT_W-1:0];
                off_reg <= hit_off[adwc_pkg::OFF_W-1:0];
                fst_reg <= 1'b0;
                fad_reg <= '0;
                tag_reg <= '0;
                exh_reg <= 1'b0;
            end
            adwc_pkg::OP_EXH:
            begin
                hit_reg <= 1'b0;
                if (is_idx(last_reg))
                begin
                    idx_reg <= last_reg[adwc_pkg::IDX_OUT_W-1:0];
                end
                else if (is_idx(used_head_reg))
                begin
                    idx_reg <= used_head_reg[adwc_pkg::IDX_OUT_W-1:0];
                end
                else
                begin
                    idx_reg <= '0;
                end
                off_reg <= {{(adwc_pkg::OFF_W-1){1'b0}}, addr_reg[0]};
                fst_reg <= 1'b0;
                fad_reg <= '0;
                tag_reg <= '0;
                exh_reg <= 1'b1;
            end
            adwc_pkg::OP_MOUT:
            begin
                hit_reg <= 1'b0;
                idx_reg <= d_reg[adwc_pkg::IDX_OUT_W-1:0];
                off_reg <= {{(adwc_pkg::OFF_W-1){1'b0}}, addr_reg[0]};
                fst_reg <= 1'b1;
                fad_reg <= {addr_reg[adwc_pkg::ADDR_W-1:1], 1'b0};
                tag_reg <= fetch_count_reg;
                exh_reg <= 1'b0;
            end
            adwc_pkg::OP_SDONE:
            begin
                hit_reg <= 1'b0;
                idx_reg <= '0;
                off_reg <= '0;
                fst_reg <= 1'b0;
                fad_reg <= '0;
                tag_reg <= '0;
                exh_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign buffer_index   = idx_reg;
    assign byte_offset    = off_reg;
    assign fetch_start    = fst_reg;
    assign fetch_addr     = fad_reg;
    assign fetch_tag      = tag_reg;
    assign pool_exhausted = exh_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/audio_dma_window_cache.sv -----
`default_nettype none
// a request walks the used list in address order, reading and then checking each visited
//   buffer, and ends in its result beat (hit, fallback or allocate and link in)
// a frame-end sweep reads and checks each used buffer and frees each stale one
// the single read port on the buffer tables makes each visit a read then a check
// one item at a time, taken only while idle; a waiting result holds the finish
// reset: async active low; free list 0..N-1, used list empty, fetch counter zero
// ----------------------------------------------------------------------------
// audio_dma_window_cache
// pool of sample rom windows with address-ordered used list and frame aging
// ----------------------------------------------------------------------------
module audio_dma_window_cache #(
    parameter int NUM_BUFFERS  = adwc_pkg::NUM_BUFFERS_DEF,
    parameter int BUFFER_BYTES = adwc_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              req_type,
    input  wire logic [adwc_pkg::ADDR_W-1:0]       rom_addr,
    input  wire logic [adwc_pkg::LEN_W-1:0]        length,
    input  wire logic [adwc_pkg::FRAME_W-1:0]      frame,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic [adwc_pkg::IDX_OUT_W-1:0]         buffer_index,
    output logic [adwc_pkg::OFF_W-1:0]             byte_offset,
    output logic                                   fetch_start,
    output logic [adwc_pkg::ADDR_W-1:0]            fetch_addr,
    output logic [adwc_pkg::TAG_W-1:0]             fetch_tag,
    output logic                                   pool_exhausted
);

    adwc_pkg::dp_op_t     op;
    adwc_pkg::dp_status_t st;

    adwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .st       (st),
        .op       (op)
    );

    adwc_dp #(
        .NUM_BUFFERS  (NUM_BUFFERS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .st             (st),
        .rom_addr       (rom_addr),
        .length         (length),
        .frame          (frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .buffer_index   (buffer_index),
        .byte_offset    (byte_offset),
        .fetch_start    (fetch_start),
        .fetch_addr     (fetch_addr),
        .fetch_tag      (fetch_tag),
        .pool_exhausted (pool_exhausted)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/adwc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adwc_checker
// port-level checks on result beats of the window cache
// ----------------------------------------------------------------------------
module adwc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        hit,
    input wire logic [9:0]  byte_offset,
    input wire logic        fetch_start,
    input wire logic [31:0] fetch_addr,
    input wire logic        pool_exhausted
);

    // a result beat has at most one outcome
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((hit && fetch_start) || (hit && pool_exhausted)
                        || (fetch_start && pool_exhausted)))
        else $error("more than one outcome on a result beat");

    // fetches start from an even address
    a_fetch_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fetch_start |-> fetch_addr[0] == 1'b0)
        else $error("odd fetch address");

    // a miss or fallback offset is only the low address bit
    a_miss_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fetch_start || pool_exhausted) |-> byte_offset[9:1] == 9'd0)
        else $error("miss offset wider than one bit");

    // a stalled beat stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

endmodule

bind audio_dma_window_cache adwc_checker u_adwc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .byte_offset    (byte_offset),
    .fetch_start    (fetch_start),
    .fetch_addr     (fetch_addr),
    .pool_exhausted (pool_exhausted)
);
`default_nettype wire

// ----- tb/tb_audio_dma_window_cache.sv -----
// ----------------------------------------------------------------------------
// tb_audio_dma_window_cache
// drives requests and frame-end sweeps through the window cache, predicts each
// result with a behavioral copy of the buffer lists and checks every beat
// ----------------------------------------------------------------------------
module tb_audio_dma_window_cache;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = adwc_pkg::NUM_BUFFERS_DEF;
    localparam int BB = adwc_pkg::BUFFER_BYTES_DEF;

    typedef struct packed {
        logic                           hit;
        logic [adwc_pkg::IDX_OUT_W-1:0] buffer_index;
        logic [adwc_pkg::OFF_W-1:0]     byte_offset;
        logic                           fetch_start;
        logic [adwc_pkg::ADDR_W-1:0]    fetch_addr;
        logic [adwc_pkg::TAG_W-1:0]     fetch_tag;
        logic                           pool_exhausted;
    } window_res_t;

    class window_scoreboard;
        logic [adwc_pkg::ADDR_W-1:0]  buf_start [NB];
        logic [adwc_pkg::FRAME_W-1:0] buf_frame [NB];
        adwc_pkg::link_t              nxt [NB];
        adwc_pkg::link_t              prv [NB];
        adwc_pkg::link_t              used_head;
        adwc_pkg::link_t              free_head;
        logic [adwc_pkg::TAG_W-1:0]   tag_count;
        window_res_t                  pending [$];
        int                           errors;

        function new();
            errors = 0;
            for (int i = 0; i < NB; i++)
            begin
                buf_start[i] = '0;
                buf_frame[i] = '0;
                nxt[i] = (i + 1 < NB) ? adwc_pkg::link_t'(i + 1) : adwc_pkg::NIL;
                prv[i] = (i == 0) ? adwc_pkg::NIL : adwc_pkg::link_t'(i - 1);
            end
            used_head = adwc_pkg::NIL;
            free_head = 0;
            tag_count = 0;
        endfunction

        function bit ok(adwc_pkg::link_t n);
            return n < NB;
        endfunction

        function void unlink(adwc_pkg::link_t n);
            adwc_pkg::link_t a;
            adwc_pkg::link_t b;
            a = nxt[n];
            b = prv[n];
            if (ok(a)) prv[a] = b;
            if (ok(b)) nxt[b] = a;
        endfunction

        function void link_after(adwc_pkg::link_t n, adwc_pkg::link_t to);
            adwc_pkg::link_t a;
            a = nxt[to];
            nxt[n] = a;
            prv[n] = to;
            if (ok(a)) prv[a] = n;
            nxt[to] = n;
        endfunction

        function void sweep_stale(logic [adwc_pkg::FRAME_W-1:0] fr);
            adwc_pkg::link_t cur;
            adwc_pkg::link_t a;
            int guard;
            logic [adwc_pkg::FRAME_W-1:0] aged;
            cur = used_head;
            guard = 0;
            while (ok(cur) && guard < NB)
            begin
                a = nxt[cur];
                guard++;
                aged = buf_frame[cur] + 1;
                if (aged < fr)
                begin
                    if (used_head == cur) used_head = a;
                    unlink(cur);
                    if (ok(free_head))
                        link_after(cur, free_head);
                    else
                    begin
                        free_head = cur;
                        nxt[cur] = adwc_pkg::NIL;
                        prv[cur] = adwc_pkg::NIL;
                    end
                end
                cur = a;
            end
            tag_count = 0;
        endfunction

        function void note_request(logic rt, logic [adwc_pkg::ADDR_W-1:0] addr,
                                   logic [adwc_pkg::LEN_W-1:0] len,
                                   logic [adwc_pkg::FRAME_W-1:0] fr);
            window_res_t r;
            adwc_pkg::link_t cur;
            adwc_pkg::link_t last;
            adwc_pkg::link_t d;
            int guard;
            bit found;
            logic [adwc_pkg::ADDR_W:0] want_end;
            logic [adwc_pkg::ADDR_W-1:0] s;
            r = '0;
            if (rt)
                sweep_stale(fr);
            else
            begin
                want_end = {1'b0, addr} + len;
                cur = used_head;
                last = adwc_pkg::NIL;
                guard = 0;
                found = 0;
                while (ok(cur) && guard < NB)
                begin
                    s = buf_start[cur];
                    guard++;
                    if (s > addr) break;
                    if (want_end <= {1'b0, s} + BB)
                    begin
                        buf_frame[cur] = fr;
                        r.hit = 1;
                        r.buffer_index = cur[adwc_pkg::IDX_OUT_W-1:0];
                        r.byte_offset = adwc_pkg::OFF_W'(addr - s);
                        found = 1;
                        break;
                    end
                    last = cur;
                    cur = nxt[cur];
                end
                if (!found)
                begin
                    d = free_head;
                    r.byte_offset = adwc_pkg::OFF_W'(addr[0]);
                    if (!ok(d))
                    begin
                        r.pool_exhausted = 1;
                        if (!ok(last)) last = used_head;
                        r.buffer_index = ok(last) ? last[adwc_pkg::IDX_OUT_W-1:0] : '0;
                    end
                    else
                    begin
                        free_head = nxt[d];
                        if (!ok(free_head)) free_head = adwc_pkg::NIL;
                        unlink(d);
                        if (ok(last))
                            link_after(d, last);
                        else if (ok(used_head))
                        begin
                            nxt[d] = used_head;
                            prv[d] = adwc_pkg::NIL;
                            prv[used_head] = d;
                            used_head = d;
                        end
                        else
                        begin
                            used_head = d;
                            nxt[d] = adwc_pkg::NIL;
                            prv[d] = adwc_pkg::NIL;
                        end
                        buf_start[d] = {addr[adwc_pkg::ADDR_W-1:1], 1'b0};
                        buf_frame[d] = fr;
                        r.buffer_index = d[adwc_pkg::IDX_OUT_W-1:0];
                        r.fetch_start = 1;
                        r.fetch_addr = buf_start[d];
                        r.fetch_tag = tag_count;
                        if (tag_count != adwc_pkg::TAG_MAX) tag_count++;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(window_res_t got);
            window_res_t w;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.hit !== w.hit)
            begin
                $error("hit exp %0h got %0h", w.hit, got.hit); errors++;
            end
            if (got.buffer_index !== w.buffer_index)
            begin
                $error("buffer_index exp %0h got %0h", w.buffer_index, got.buffer_index);
                errors++;
            end
            if (got.byte_offset !== w.byte_offset)
            begin
                $error("byte_offset exp %0h got %0h", w.byte_offset, got.byte_offset);
                errors++;
            end
            if (got.fetch_start !== w.fetch_start)
            begin
                $error("fetch_start exp %0h got %0h", w.fetch_start, got.fetch_start);
                errors++;
            end
            if (got.fetch_addr !== w.fetch_addr)
            begin
                $error("fetch_addr exp %0h got %0h", w.fetch_addr, got.fetch_addr);
                errors++;
            end
            if (got.fetch_tag !== w.fetch_tag)
            begin
                $error("fetch_tag exp %0h got %0h", w.fetch_tag, got.fetch_tag);
                errors++;
            end
            if (got.pool_exhausted !== w.pool_exhausted)
            begin
                $error("pool_exhausted exp %0h got %0h", w.pool_exhausted,
                       got.pool_exhausted);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic req_type;
    logic [adwc_pkg::ADDR_W-1:0] rom_addr;
    logic [adwc_pkg::LEN_W-1:0] length;
    logic [adwc_pkg::FRAME_W-1:0] frame;
    logic out_valid;
    logic out_stall;
    logic hit;
    logic [adwc_pkg::IDX_OUT_W-1:0] buffer_index;
    logic [adwc_pkg::OFF_W-1:0] byte_offset;
    logic fetch_start;
    logic [adwc_pkg::ADDR_W-1:0] fetch_addr;
    logic [adwc_pkg::TAG_W-1:0] fetch_tag;
    logic pool_exhausted;

    window_scoreboard sb;
    logic [adwc_pkg::FRAME_W-1:0] cur_frame;
    logic [adwc_pkg::ADDR_W-1:0] region_base;
    int burst_left;
    int stall_mode;

    audio_dma_window_cache dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .rom_addr(rom_addr), .length(length), .frame(frame),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .buffer_index(buffer_index), .byte_offset(byte_offset),
        .fetch_start(fetch_start), .fetch_addr(fetch_addr), .fetch_tag(fetch_tag),
        .pool_exhausted(pool_exhausted)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("** audio_dma_window_cache: FAILED **");
        $finish;
    end

    // receiver stall pattern: phases of none, light, heavy and periodic stalls
    initial
    begin
        int cnt;
        out_stall = 0;
        cnt = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            cnt++;
            if (cnt % 200 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (cnt % 5 < 2);
            endcase
        end
    end

    // result monitor
    initial
    begin
        window_res_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.hit = hit;
                got.buffer_index = buffer_index;
                got.byte_offset = byte_offset;
                got.fetch_start = fetch_start;
                got.fetch_addr = fetch_addr;
                got.fetch_tag = fetch_tag;
                got.pool_exhausted = pool_exhausted;
                sb.check_result(got);
            end
        end
    end

    // one beat; valid stays high across back-to-back beats within a burst
    task automatic send_beat(logic rt, logic [adwc_pkg::ADDR_W-1:0] a,
                             logic [adwc_pkg::LEN_W-1:0] l,
                             logic [adwc_pkg::FRAME_W-1:0] f);
        in_valid <= 1;
        req_type <= rt;
        rom_addr <= a;
        length <= l;
        frame <= f;
        do @(posedge clk); while (in_stall);
        sb.note_request(rt, a, l, f);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    task automatic random_item();
        int pick;
        logic [adwc_pkg::ADDR_W-1:0] a;
        logic [adwc_pkg::LEN_W-1:0] l;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            cur_frame = cur_frame + $urandom_range(0, 3);
            send_beat(1, $urandom, $urandom, cur_frame);
        end
        else if (pick < 10)
            send_beat(0, $urandom, $urandom, $urandom);
        else
        begin
            // clustered addresses so hits and ordered inserts are common
            a = region_base + $urandom_range(0, 40 * BB);
            l = ($urandom_range(0, 7) == 0) ? adwc_pkg::LEN_W'($urandom)
                                            : adwc_pkg::LEN_W'($urandom_range(0, 600));
            send_beat(0, a, l, cur_frame);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        req_type = 0;
        rom_addr = 0;
        length = 0;
        frame = 0;
        burst_left = 0;
        cur_frame = 5;
        region_base = 32'h0001_0000;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty sweep, extremes, hits, wrap of aging and coverage
        send_beat(1, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        send_beat(0, 32'h0, 16'h0, 32'h0);
        send_beat(0, 32'h0, 16'd512, 32'h0);
        send_beat(0, 32'h1, 16'd511, 32'h0);
        send_beat(0, 32'h1, 16'd512, 32'h1);
        send_beat(0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_beat(0, 32'hFFFF_FE01, 16'd500, 32'hFFFF_FFFF);
        send_beat(0, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF);
        send_beat(0, 32'h0000_D200, 16'h0200, 32'h2);
        send_beat(0, 32'h0000_D3FF, 16'h1, 32'h2);
        send_beat(0, 32'h0000_8000, 16'h0, 32'h2);
        send_beat(1, 32'h0, 16'h0, 32'h1);
        send_beat(1, 32'h0, 16'h0, 32'h4);
        send_beat(0, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555);
        send_beat(0, 32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA);
        // fill the pool to exhaustion, then fallbacks and a full sweep
        for (int i = 0; i < NB + 3; i++)
            send_beat(0, 32'h0100_0000 + i * 32'h1000, 16'd4, 32'h6);
        send_beat(0, 32'h0000_0001, 16'd700, 32'h6);
        send_beat(0, 32'h0100_5003, 16'd900, 32'h6);
        send_beat(1, 32'h0, 16'h0, 32'h9);

        for (int n = 0; n < 440; n++)
        begin
            if (n % 150 == 149)
            begin
                // periodically refill the pool to exercise exhaustion again
                for (int i = 0; i < NB + 2; i++)
                    send_beat(0, $urandom, 16'd8, cur_frame);
                cur_frame = cur_frame + 3;
                send_beat(1, 0, 0, cur_frame);
                region_base = $urandom;
            end
            random_item();
        end
        in_valid <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** audio_dma_window_cache: PASSED **");
        else
            $display("** audio_dma_window_cache: FAILED **");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/adwc_pkg.sv
hw/rtl/adwc_ram.sv
hw/rtl/adwc_ctrl.sv
hw/rtl/adwc_dp.sv
hw/rtl/audio_dma_window_cache.sv
hw/rtl/adwc_checker.sv
tb/tb_audio_dma_window_cache.sv
